// ===== rtl/core/dcc_pkg.sv =====
// Package: shared types and constants for the DCC locomotive packet builder
`timescale 1ns / 1ps

package dcc_pkg;

  localparam int unsigned PktMaxBytes = 5;
  localparam int unsigned LenW        = 3;

  typedef enum logic [2:0] {
    FUNC_SPEED14  = 3'd0,
    FUNC_SPEED28  = 3'd1,
    FUNC_SPEED128 = 3'd2,
    FUNC_BASIC    = 3'd3,
    FUNC_EXT      = 3'd4
  } func_code_t;

  localparam logic [7:0] LongAddrBase = 8'hC0;
  localparam logic [7:0] Speed128Inst = 8'h3F;
  localparam logic [7:0] DirReverse   = 8'h40;
  localparam logic [7:0] DirForward   = 8'h60;
  localparam logic [7:0] Fg0Base      = 8'h80;
  localparam logic [7:0] Fg1Base      = 8'hB0;
  localparam logic [7:0] Fg2Base      = 8'hA0;
  localparam logic [7:0] Fwd128       = 8'h80;
  localparam logic [13:0] ShortLimitUs = 14'd127;
  localparam logic [13:0] ShortLimitEu = 14'd100;

  typedef struct packed {
    logic [2:0]  func;
    logic [13:0] loco_address;
    logic        direction;
    logic [7:0]  speed_code;
    logic [2:0]  function_group;
    logic [7:0]  function_bits;
  } dcc_cmd_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
    logic       rejected;
    logic [3:0] command_class;
  } dcc_res_t;

  typedef struct packed {
    logic [PktMaxBytes-1:0][7:0] bytes;
    logic [LenW-1:0]             len;
    logic                        rejected;
    logic [3:0]                  command_class;
  } dcc_frame_t;

  function automatic logic [7:0] ext_group_code(input logic [2:0] grp);
    logic [7:0] code;
    case (grp)
      3'd0:    code = 8'hDE;
      3'd1:    code = 8'hDF;
      3'd2:    code = 8'hD8;
      3'd3:    code = 8'hD9;
      3'd4:    code = 8'hDA;
      3'd5:    code = 8'hDB;
      3'd6:    code = 8'hDC;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/core/dcc_encoder.sv =====
// Encoder: builds the full packet frame for one registered command
`timescale 1ns / 1ps

module dcc_encoder (
  input  dcc_pkg::dcc_cmd_t   cmd,
  input  logic                address_style,
  output dcc_pkg::dcc_frame_t frame
);
  import dcc_pkg::*;

  logic [13:0]    limit;
  logic           long_addr;
  logic [7:0]     addr0;
  logic [7:0]     addr1;
  logic [7:0]     inst0;
  logic [7:0]     inst1;
  logic           two_inst;
  logic           reject;
  logic [3:0]     cls;
  logic [7:0]     spd_enc;
  logic [3:0][7:0] body;
  logic [LenW-1:0] body_len;
  logic [7:0]     check;

  always_comb begin
    limit     = address_style ? ShortLimitEu : ShortLimitUs;
    long_addr = cmd.loco_address > limit;
    addr0     = long_addr ? (LongAddrBase + {2'b00, cmd.loco_address[13:8]})
                          : cmd.loco_address[7:0];
    addr1     = cmd.loco_address[7:0];

    if (cmd.speed_code == 8'd0) begin
      spd_enc = 8'h00;
    end else if (cmd.speed_code == 8'd1) begin
      spd_enc = 8'h01;
    end else if (cmd.func == FUNC_SPEED14) begin
      spd_enc = {4'h1, cmd.speed_code[3:0]};
    end else begin
      spd_enc = {3'b000, cmd.speed_code[0], cmd.speed_code[4:1]};
    end

    inst0    = 8'h00;
    inst1    = 8'h00;
    two_inst = 1'b0;
    reject   = (cmd.loco_address == 14'd0);
    cls      = 4'd0;
    case (cmd.func)
      FUNC_SPEED14, FUNC_SPEED28: begin
        inst0 = (cmd.direction ? DirForward : DirReverse) + spd_enc;
      end
      FUNC_SPEED128: begin
        inst0    = Speed128Inst;
        inst1    = (cmd.direction ? Fwd128 : 8'h00) + cmd.speed_code;
        two_inst = 1'b1;
        if (cmd.speed_code[7]) reject = 1'b1;
      end
      FUNC_BASIC: begin
        cls = {1'b0, cmd.function_group} + 4'd1;
        case (cmd.function_group)
          3'd0:    inst0 = Fg0Base + {3'b000, cmd.function_bits[4:0]};
          3'd1:    inst0 = Fg1Base + {4'h0, cmd.function_bits[3:0]};
          3'd2:    inst0 = Fg2Base + {4'h0, cmd.function_bits[3:0]};
          default: reject = 1'b1;
        endcase
      end
      FUNC_EXT: begin
        cls      = {1'b0, cmd.function_group} + 4'd4;
        inst0    = ext_group_code(cmd.function_group);
        inst1    = cmd.function_bits;
        two_inst = 1'b1;
        if (cmd.function_group == 3'd7) reject = 1'b1;
      end
      default: reject = 1'b1;
    endcase

    if (long_addr) begin
      body = {inst1, inst0, addr1, addr0};
    end else begin
      body = {8'h00, inst1, inst0, addr0};
    end
    body_len = 3'd2 + {2'b00, long_addr} + {2'b00, two_inst};
    check    = addr0 ^ (long_addr ? addr1 : 8'h00) ^ inst0 ^ (two_inst ? inst1 : 8'h00);

    for (int k = 0; k < PktMaxBytes; k++) begin
      if (k < 4 && LenW'(k) < body_len) begin
        frame.bytes[k] = body[k[1:0]];
      end else if (LenW'(k) == body_len) begin
        frame.bytes[k] = check;
      end else begin
        frame.bytes[k] = 8'h00;
      end
    end
    frame.len           = body_len + 3'd1;
    frame.rejected      = 1'b0;
    frame.command_class = cls;

    if (reject) begin
      frame.bytes         = '0;
      frame.len           = 3'd1;
      frame.rejected      = 1'b1;
      frame.command_class = 4'd0;
    end
  end

endmodule

// ===== rtl/core/dcc_serializer.sv =====
// Serialiser: frame buffer that shifts packet bytes into the result register
`timescale 1ns / 1ps

module dcc_serializer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  dcc_pkg::dcc_frame_t frame,
  output logic                can_load,
  output logic                out_strobe,
  output dcc_pkg::dcc_res_t   out_res
);
  import dcc_pkg::*;

  logic [PktMaxBytes-1:0][7:0] buf_r, buf_nxt;
  logic [LenW-1:0]             rem_r, rem_nxt;
  logic                        rej_r, rej_nxt;
  logic [3:0]                  cls_r, cls_nxt;
  logic                        strobe_r, strobe_nxt;
  dcc_res_t                    res_r, res_nxt;

  assign can_load   = (rem_r <= 3'd1);
  assign out_strobe = strobe_r;
  assign out_res    = res_r;

  always_comb begin
    buf_nxt = buf_r;
    rem_nxt = rem_r;
    rej_nxt = rej_r;
    cls_nxt = cls_r;
    if (load) begin
      buf_nxt = frame.bytes;
      rem_nxt = frame.len;
      rej_nxt = frame.rejected;
      cls_nxt = frame.command_class;
    end else if (rem_r != 3'd0) begin
      buf_nxt = {8'h00, buf_r[PktMaxBytes-1:1]};
      rem_nxt = rem_r - 3'd1;
    end
    strobe_nxt            = (rem_r != 3'd0);
    res_nxt.packet_byte   = buf_r[0];
    res_nxt.last_byte     = (rem_r == 3'd1);
    res_nxt.rejected      = rej_r;
    res_nxt.command_class = cls_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      rem_r    <= rem_nxt;
      strobe_r <= strobe_nxt;
    end
    buf_r <= buf_nxt;
    rej_r <= rej_nxt;
    cls_r <= cls_nxt;
    res_r <= res_nxt;
  end

endmodule

// ===== rtl/core/dcc_loco_packet_builder_top.sv =====
// DCC locomotive packet builder: an accepted command is registered, loaded into the
// frame buffer, and its first byte is registered out, later while an earlier packet is
// still going out. One byte per cycle; a command holds the frame buffer while its bytes
// go out (1 for a rejection, else 3 to 5). A transaction is accepted as the held command
// moves into the frame buffer, or at once when none is held; the receiver cannot stall.
// Synchronous active-low reset clears the pipeline and sets address style to US.
`timescale 1ns / 1ps

module dcc_loco_packet_builder_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  dcc_pkg::dcc_cmd_t in_cmd,
  output logic              out_strobe,
  output dcc_pkg::dcc_res_t out_res,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);
  import dcc_pkg::*;

  dcc_cmd_t   cmd_r, cmd_nxt;
  logic       cmd_valid_r, cmd_valid_nxt;
  logic       style_r, style_nxt;
  logic       accept;
  logic       can_load;
  logic       load;
  dcc_frame_t frame;

  assign load   = cmd_valid_r && can_load;
  assign busy   = cmd_valid_r && !can_load;
  assign accept = start && !busy;

  always_comb begin
    cmd_nxt       = accept ? in_cmd : cmd_r;
    cmd_valid_nxt = accept || busy;
    style_nxt     = cfg_we ? cfg_wdata : style_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
      style_r     <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
      style_r     <= style_nxt;
    end
    cmd_r <= cmd_nxt;
  end

  dcc_encoder u_encoder (
    .cmd           (cmd_r),
    .address_style (style_r),
    .frame         (frame)
  );

  dcc_serializer u_serializer (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .frame      (frame),
    .can_load   (can_load),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_res.rejected |-> out_res.last_byte && out_res.packet_byte == 8'h00)
    else $error("rejection not a single zero byte");

  a_packet_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_res.last_byte |=> out_strobe)
    else $error("gap inside packet");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe && !busy)
    else $error("activity straight after reset");

  a_class_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_res.last_byte |=> $stable(out_res.command_class))
    else $error("command class changed within packet");

endmodule

// ===== test/dcc_loco_packet_builder_top_tb.sv =====
// Testbench for the DCC locomotive packet builder: directed command table, then random commands
`timescale 1ns / 1ps

module dcc_loco_packet_builder_top_tb;
  import dcc_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int DirRows    = 25;
  localparam int SettleCyc  = 10;

  localparam logic [2:0] FuncUnused5 = 3'd5;
  localparam logic [2:0] FuncUnused6 = 3'd6;
  localparam logic [2:0] FuncUnused7 = 3'd7;

  typedef struct packed {
    dcc_cmd_t        cmd;
    logic [2:0]      n_typed;
    logic [4:0][7:0] pkt;
    logic            rej;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  dcc_cmd_t in_cmd;
  logic     out_strobe;
  dcc_res_t out_res;
  logic     cfg_we;
  logic     cfg_wdata;

  dcc_res_t expected_bytes[$];
  dir_row_t script [0:DirRows-1];
  logic     eu_style;
  int       mismatches;
  int       cycles;

  dcc_loco_packet_builder_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_cmd     (in_cmd),
    .out_strobe (out_strobe),
    .out_res    (out_res),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin : check_bytes
    dcc_res_t want;
    if (rst_n && out_strobe) begin
      if (expected_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected byte %h last %b rej %b class %0d", $time,
                 out_res.packet_byte, out_res.last_byte, out_res.rejected,
                 out_res.command_class);
      end else begin
        want = expected_bytes.pop_front();
        if (out_res !== want) begin
          mismatches++;
          $display("%0t: expected byte %h last %b rej %b class %0d, got byte %h last %b rej %b class %0d",
                   $time, want.packet_byte, want.last_byte, want.rejected, want.command_class,
                   out_res.packet_byte, out_res.last_byte, out_res.rejected,
                   out_res.command_class);
        end
      end
    end
  end

  function automatic dcc_cmd_t cmd_of(input logic [2:0] f, input logic [13:0] a,
                                      input logic d, input logic [7:0] s,
                                      input logic [2:0] g, input logic [7:0] b);
    dcc_cmd_t c;
    c.func           = f;
    c.loco_address   = a;
    c.direction      = d;
    c.speed_code     = s;
    c.function_group = g;
    c.function_bits  = b;
    return c;
  endfunction

  function automatic dir_row_t row(input dcc_cmd_t c, input logic [2:0] n,
                                   input logic [4:0][7:0] p, input logic rej);
    dir_row_t r;
    r.cmd     = c;
    r.n_typed = n;
    r.pkt     = p;
    r.rej     = rej;
    return r;
  endfunction

  function automatic dcc_cmd_t rand_cmd();
    dcc_cmd_t c;
    c.func = ($urandom_range(0, 99) < 92) ? 3'($urandom_range(0, 4))
                                          : 3'($urandom_range(5, 7));
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 6))
          0:       c.loco_address = 14'd0;
          1:       c.loco_address = 14'd1;
          2:       c.loco_address = 14'd100;
          3:       c.loco_address = 14'd101;
          4:       c.loco_address = 14'd127;
          5:       c.loco_address = 14'd128;
          default: c.loco_address = 14'd16383;
        endcase
      end
      1, 2, 3, 4: c.loco_address = 14'($urandom_range(1, 127));
      5, 6, 7, 8: c.loco_address = 14'($urandom_range(128, 16383));
      default:    c.loco_address = 14'($urandom_range(0, 16383));
    endcase
    c.direction = 1'($urandom_range(0, 1));
    if (c.func == FUNC_SPEED128 && $urandom_range(0, 99) < 85)
      c.speed_code = 8'($urandom_range(0, 127));
    else
      c.speed_code = 8'($urandom_range(0, 255));
    if (c.func == FUNC_BASIC && $urandom_range(0, 99) < 85)
      c.function_group = 3'($urandom_range(0, 2));
    else if (c.func == FUNC_EXT && $urandom_range(0, 99) < 90)
      c.function_group = 3'($urandom_range(0, 6));
    else
      c.function_group = 3'($urandom_range(0, 7));
    c.function_bits = 8'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic queue_packet(input dcc_cmd_t c);
    logic [4:0][7:0] pkt;
    logic [7:0]      sp;
    logic [7:0]      chk;
    logic [13:0]     lim;
    logic [3:0]      cls;
    logic            bad;
    int              n;
    dcc_res_t        r;
    n   = 0;
    cls = 4'd0;
    bad = 1'b0;
    chk = 8'h00;
    pkt = '0;
    lim = eu_style ? ShortLimitEu : ShortLimitUs;
    if (c.loco_address == 14'd0 || c.func > FUNC_EXT) begin
      bad = 1'b1;
    end else begin
      if (c.loco_address <= lim) begin
        pkt[0] = c.loco_address[7:0];
        n = 1;
      end else begin
        pkt[0] = LongAddrBase + {2'b00, c.loco_address[13:8]};
        pkt[1] = c.loco_address[7:0];
        n = 2;
      end
      case (c.func)
        FUNC_SPEED14, FUNC_SPEED28: begin
          if (c.speed_code == 8'd0)
            sp = 8'h00;
          else if (c.speed_code == 8'd1)
            sp = 8'h01;
          else if (c.func == FUNC_SPEED14)
            sp = {4'h1, c.speed_code[3:0]};
          else
            sp = {3'b000, c.speed_code[0], c.speed_code[4:1]};
          pkt[n] = (c.direction ? DirForward : DirReverse) + sp;
          n++;
        end
        FUNC_SPEED128: begin
          if (c.speed_code[7]) begin
            bad = 1'b1;
          end else begin
            pkt[n]   = Speed128Inst;
            pkt[n+1] = (c.direction ? Fwd128 : 8'h00) | c.speed_code;
            n += 2;
          end
        end
        FUNC_BASIC: begin
          case (c.function_group)
            3'd0:    pkt[n] = Fg0Base + {3'b000, c.function_bits[4:0]};
            3'd1:    pkt[n] = Fg1Base + {4'h0, c.function_bits[3:0]};
            3'd2:    pkt[n] = Fg2Base + {4'h0, c.function_bits[3:0]};
            default: bad = 1'b1;
          endcase
          n++;
          cls = {1'b0, c.function_group} + 4'd1;
        end
        default: begin
          if (c.function_group == 3'd7) begin
            bad = 1'b1;
          end else begin
            pkt[n]   = (c.function_group < 3'd2) ? 8'hDE + {5'b00000, c.function_group}
                                                 : 8'hD6 + {5'b00000, c.function_group};
            pkt[n+1] = c.function_bits;
            n += 2;
            cls = {1'b0, c.function_group} + 4'd4;
          end
        end
      endcase
    end
    if (bad) begin
      r.packet_byte   = 8'h00;
      r.last_byte     = 1'b1;
      r.rejected      = 1'b1;
      r.command_class = 4'd0;
      expected_bytes.push_back(r);
    end else begin
      for (int k = 0; k < n; k++) chk ^= pkt[k];
      pkt[n] = chk;
      n++;
      for (int k = 0; k < n; k++) begin
        r.packet_byte   = pkt[k];
        r.last_byte     = (k == n - 1);
        r.rejected      = 1'b0;
        r.command_class = cls;
        expected_bytes.push_back(r);
      end
    end
  endtask

  task automatic send_cmd(input dcc_cmd_t c, input int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  = 1'b1;
    in_cmd = c;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
  endtask

  task automatic write_style(input logic v);
    drain();
    repeat (SettleCyc) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    eu_style  = v;
  endtask

  task automatic run_random(input int count, input bit steady, input int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) drain();
      send_cmd(rand_cmd(), steady ? 0 : $urandom_range(0, 9));
      queue_packet(in_cmd);
    end
  endtask

  initial begin : stimulus
    dcc_res_t r;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_cmd     = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = 1'b0;
    eu_style   = 1'b0;
    mismatches = 0;
    cycles     = 0;

    script[0]  = row(cmd_of(FUNC_SPEED14, 14'd3, 1'b1, 8'd0, 3'd0, 8'h00), 3'd3,
                     {16'h0, 8'h63, 8'h60, 8'h03}, 1'b0);
    script[1]  = row(cmd_of(FUNC_SPEED14, 14'd3, 1'b0, 8'd1, 3'd0, 8'h00), 3'd3,
                     {16'h0, 8'h42, 8'h41, 8'h03}, 1'b0);
    script[2]  = row(cmd_of(FUNC_SPEED14, 14'd127, 1'b1, 8'hFF, 3'd7, 8'hFF), 3'd0, '0, 1'b0);
    script[3]  = row(cmd_of(FUNC_SPEED28, 14'd1, 1'b0, 8'hFF, 3'd0, 8'h00), 3'd0, '0, 1'b0);
    script[4]  = row(cmd_of(FUNC_SPEED28, 14'd128, 1'b1, 8'd2, 3'd0, 8'h00), 3'd0, '0, 1'b0);
    script[5]  = row(cmd_of(FUNC_SPEED128, 14'd16383, 1'b1, 8'd127, 3'd0, 8'h00),
                     3'd0, '0, 1'b0);
    script[6]  = row(cmd_of(FUNC_SPEED128, 14'd5, 1'b0, 8'd0, 3'd0, 8'h00), 3'd4,
                     {8'h0, 8'h3A, 8'h00, 8'h3F, 8'h05}, 1'b0);
    script[7]  = row(cmd_of(FUNC_SPEED128, 14'd200, 1'b1, 8'd128, 3'd0, 8'h00), 3'd1, '0, 1'b1);
    script[8]  = row(cmd_of(FUNC_SPEED128, 14'd1, 1'b0, 8'd255, 3'd0, 8'h00), 3'd1, '0, 1'b1);
    script[9]  = row(cmd_of(FUNC_SPEED14, 14'd0, 1'b1, 8'd5, 3'd0, 8'h00), 3'd1, '0, 1'b1);
    script[10] = row(cmd_of(FuncUnused5, 14'd10, 1'b1, 8'd5, 3'd0, 8'h00), 3'd1, '0, 1'b1);
    script[11] = row(cmd_of(FuncUnused6, 14'd16383, 1'b0, 8'd0, 3'd1, 8'hFF), 3'd1, '0, 1'b1);
    script[12] = row(cmd_of(FuncUnused7, 14'd0, 1'b1, 8'hFF, 3'd7, 8'hFF), 3'd1, '0, 1'b1);
    script[13] = row(cmd_of(FUNC_BASIC, 14'd42, 1'b1, 8'd0, 3'd0, 8'hFF), 3'd0, '0, 1'b0);
    script[14] = row(cmd_of(FUNC_BASIC, 14'd300, 1'b0, 8'd0, 3'd1, 8'hFF), 3'd0, '0, 1'b0);
    script[15] = row(cmd_of(FUNC_BASIC, 14'd127, 1'b1, 8'd0, 3'd2, 8'h00), 3'd0, '0, 1'b0);
    script[16] = row(cmd_of(FUNC_BASIC, 14'd7, 1'b1, 8'd0, 3'd3, 8'h55), 3'd1, '0, 1'b1);
    for (int g = 0; g < 7; g++)
      script[17+g] = row(cmd_of(FUNC_EXT, 14'(1000 * g + 2), g[0], 8'(g * 37), 3'(g),
                                8'(g * 37)),
                         3'd0, '0, 1'b0);
    script[24] = row(cmd_of(FUNC_EXT, 14'd99, 1'b0, 8'd0, 3'd7, 8'hAA), 3'd1, '0, 1'b1);

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < DirRows; i++) begin
      send_cmd(script[i].cmd, $urandom_range(0, 9));
      if (script[i].n_typed == 3'd0) begin
        queue_packet(script[i].cmd);
      end else begin
        for (int k = 0; k < script[i].n_typed; k++) begin
          r.packet_byte   = script[i].pkt[k];
          r.last_byte     = (k == script[i].n_typed - 1);
          r.rejected      = script[i].rej;
          r.command_class = 4'd0;
          expected_bytes.push_back(r);
        end
      end
    end

    write_style(1'b1);
    run_random(90, 1'b0, 45);
    write_style(1'b0);
    run_random(90, 1'b1, -1);
    write_style(1'b1);
    run_random(75, 1'b0, -1);

    drain();
    repeat (SettleCyc) @(negedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/dcc_pkg.sv
rtl/core/dcc_encoder.sv
rtl/core/dcc_serializer.sv
rtl/core/dcc_loco_packet_builder_top.sv
test/dcc_loco_packet_builder_top_tb.sv
